// ----- src/bubble_sort_engine_core_assert.svh -----
// ----------------------------------------------------------------------------
// bubble sort engine assertion macros
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORT_ENGINE_CORE_ASSERT_SVH
`define BUBBLE_SORT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define BSE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bubble sort engine check failed");

// next-cycle implication
`define BSE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bubble sort engine check failed");

`endif

// ----- src/bse_pkg.sv -----
// ----------------------------------------------------------------------------
// bse_pkg
// Types and constants shared by the bubble sort engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bse_pkg;

	// default capacity of the element store
	localparam int MAX_ITEMS_DEF = 64;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// one classified item as it travels through the queue
	typedef struct packed {
		logic signed [31:0] value;
		logic               keep;
		logic               last;
	} bse_item_t;

	// back-end sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SORT_RD0,
		ST_SORT_FIRST,
		ST_SORT_RUN,
		ST_SORT_TAIL,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} bse_state_t;

endpackage

// ----- src/bse_front.sv -----
// ----------------------------------------------------------------------------
// bse_front
// Accepts input items and marks each one as stored or dropped, depending on
// how many elements of the current run already fill the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bse_front #(
	parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic signed [31:0]  value,
	input  logic                last,
	input  logic                q_full,
	output logic                push,
	output bse_pkg::bse_item_t  push_item
);
	import bse_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [CW-1:0] run_cnt_q;
	logic          keep;

	// handshake toward the queue
	assign item_ready = !q_full;
	assign push       = item_valid && item_ready;

	// an element beyond capacity is dropped, its last flag still counts
	assign keep = (run_cnt_q < CW'(MAX_ITEMS));

	assign push_item.value = value;
	assign push_item.keep  = keep;
	assign push_item.last  = last;

	// elements kept in the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (push) begin
			if (last) begin
				run_cnt_q <= '0;
			end else if (keep) begin
				run_cnt_q <= run_cnt_q + CW'(1);
			end
		end
	end

endmodule

// ----- src/bse_fifo.sv -----
// ----------------------------------------------------------------------------
// bse_fifo
// Small queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bubble_sort_engine_core_assert.svh"

module bse_fifo #(
	parameter int DEPTH = bse_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bse_pkg::bse_item_t  push_item,
	output logic                full,
	input  logic                pop,
	output bse_pkg::bse_item_t  pop_item,
	output logic                empty
);
	import bse_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW = $clog2(DEPTH + 1);

	bse_item_t     entries_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [FW-1:0] fill_q;

	assign full     = (fill_q == FW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign pop_item = entries_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	`BSE_ASSERT_NOW(a_fifo_no_overflow, push, !full)
	`BSE_ASSERT_NOW(a_fifo_no_underflow, pop, !empty)
	`BSE_ASSERT_NEXT(a_fifo_fill_up, push && !pop, fill_q == $past(fill_q) + FW'(1))

endmodule

// ----- src/bse_back.sv -----
// ----------------------------------------------------------------------------
// bse_back
// Stores queued elements, sorts the run in place with bubbling passes over
// a dual-port store, then emits the sorted run through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bubble_sort_engine_core_assert.svh"

module bse_back #(
	parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  bse_pkg::bse_item_t  q_item,
	output logic                pop,
	output logic                result_valid,
	input  logic                result_ready,
	output logic signed [31:0]  sorted_value,
	output logic                end_of_run
);
	import bse_pkg::*;

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	bse_state_t         state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [IW-1:0]      k_q, k_d;
	logic [IW-1:0]      end_q, end_d;
	logic [IW-1:0]      last_idx_q, last_idx_d;
	logic signed [31:0] carry_q, carry_d;
	logic               swapped_q, swapped_d;
	logic               out_valid_q, out_valid_d;
	logic               out_load;
	logic signed [31:0] sorted_q;
	logic               eor_q;

	// store ports
	logic signed [31:0] store_q [MAX_ITEMS];
	logic signed [31:0] rdata_q;
	logic               we;
	logic [IW-1:0]      waddr;
	logic signed [31:0] wdata;
	logic [IW-1:0]      raddr;

	logic [CW-1:0]      run_len;
	logic [CW-1:0]      run_top;

	// length of the run once the popped item is counted
	assign run_len = count_q + CW'(q_item.keep);
	assign run_top = run_len - CW'(1);

	// element store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[raddr];
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	// working registers of the sort and emit sequence
	always_ff @(posedge clk) begin
		k_q        <= k_d;
		end_q      <= end_d;
		last_idx_q <= last_idx_d;
		carry_q    <= carry_d;
		swapped_q  <= swapped_d;
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			sorted_q <= rdata_q;
			eor_q    <= (k_q == last_idx_q);
		end
	end

	assign result_valid = out_valid_q;
	assign sorted_value = sorted_q;
	assign end_of_run   = eor_q;

	// sequencer: load, bubbling passes, emission
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		k_d         = k_q;
		end_d       = end_q;
		last_idx_d  = last_idx_q;
		carry_d     = carry_q;
		swapped_d   = swapped_q;
		out_valid_d = out_valid_q && !result_ready;
		out_load    = 1'b0;
		pop         = 1'b0;
		we          = 1'b0;
		waddr       = k_q;
		wdata       = carry_q;
		raddr       = k_q;

		case (state_q)
			ST_LOAD: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (q_item.keep) begin
						we      = 1'b1;
						waddr   = count_q[IW-1:0];
						wdata   = q_item.value;
						count_d = run_len;
					end
					if (q_item.last) begin
						last_idx_d = run_top[IW-1:0];
						end_d      = run_top[IW-1:0];
						k_d        = '0;
						if (run_top == '0) begin
							state_d = ST_EMIT_RD;
						end else begin
							state_d = ST_SORT_RD0;
						end
					end
				end
			end
			ST_SORT_RD0: begin
				raddr     = '0;
				swapped_d = 1'b0;
				state_d   = ST_SORT_FIRST;
			end
			ST_SORT_FIRST: begin
				carry_d = rdata_q;
				raddr   = IW'(1);
				k_d     = IW'(1);
				state_d = ST_SORT_RUN;
			end
			ST_SORT_RUN: begin
				// the larger value keeps bubbling, the smaller one settles
				we    = 1'b1;
				waddr = k_q - IW'(1);
				if (carry_q > rdata_q) begin
					wdata     = rdata_q;
					swapped_d = 1'b1;
				end else begin
					wdata   = carry_q;
					carry_d = rdata_q;
				end
				if (k_q == end_q) begin
					state_d = ST_SORT_TAIL;
				end else begin
					raddr = k_q + IW'(1);
					k_d   = k_q + IW'(1);
				end
			end
			ST_SORT_TAIL: begin
				we    = 1'b1;
				waddr = end_q;
				wdata = carry_q;
				// a pass without swaps leaves the run in order
				if (end_q == IW'(1) || !swapped_q) begin
					k_d     = '0;
					state_d = ST_EMIT_RD;
				end else begin
					end_d   = end_q - IW'(1);
					state_d = ST_SORT_RD0;
				end
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (!out_valid_q || result_ready) begin
					out_load    = 1'b1;
					out_valid_d = 1'b1;
					if (k_q == last_idx_q) begin
						count_d = '0;
						state_d = ST_LOAD;
					end else begin
						k_d     = k_q + IW'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	`BSE_ASSERT_NOW(a_store_has_room, pop && q_item.keep, count_q < CW'(MAX_ITEMS))
	`BSE_ASSERT_NOW(a_pass_has_work, state_q == ST_SORT_RD0, end_q != '0)
	`BSE_ASSERT_NOW(a_run_index_in_pass, state_q == ST_SORT_RUN, k_q != '0 && k_q <= end_q)
	`BSE_ASSERT_NEXT(a_run_end_returns, out_load && (k_q == last_idx_q),
		state_q == ST_LOAD && count_q == '0)

endmodule

// ----- src/bubble_sort_engine_core.sv -----
// Bubble sort engine: collects a run of signed 32-bit values, one per item,
// and when the item flagged last arrives, sorts the run ascending (stable,
// signed compare) and emits it with end_of_run on the final value. Values
// beyond MAX_ITEMS in one run are dropped. Items enter a small queue at one
// per cycle while it has room and are stored at one per cycle while the back
// end is loading. The sort then runs bubbling passes over a dual-port element
// store, up to n - 1 passes for a run of n values (fewer once a pass makes no
// swap). Each value is then read from the store and loaded into the output
// register, which holds it while the receiver stalls.
// ----------------------------------------------------------------------------
// bubble_sort_engine_core
// Top level: front classifier, item queue and sort/emit back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bubble_sort_engine_core #(
	parameter int MAX_ITEMS = bse_pkg::MAX_ITEMS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] sorted_value,
	output logic               end_of_run
);
	import bse_pkg::*;

	bse_item_t push_item;
	bse_item_t pop_item;
	logic      push;
	logic      pop;
	logic      q_full;
	logic      q_empty;

	// input side
	bse_front #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.value     (value),
		.last      (last),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	bse_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (pop),
		.pop_item (pop_item),
		.empty    (q_empty)
	);

	// store, sort and emit
	bse_back #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (pop_item),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sorted_value(sorted_value),
		.end_of_run  (end_of_run)
	);

endmodule

// ----- tb/sv/tb_bubble_sort_engine_core.sv -----
// ----------------------------------------------------------------------------
// tb_bubble_sort_engine_core
// Self-checking bench for the bubble sort engine. Runs of signed values are
// sent over the item channel, with a stable ascending sort predicted in the
// bench. Each sorted value and end mark is compared as it leaves the block.
// Directed runs cover the value extremes, presorted, reversed and repeated
// runs, and an overfull store. Random runs follow. Sender bursts and
// receiver stalls vary from run to run, and one long receiver hold-off makes
// the input back up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bubble_sort_engine_core;

	localparam int STORE_DEPTH  = bse_pkg::MAX_ITEMS_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 12;
	localparam int DRAIN_SLACK  = 40;

	localparam logic signed [31:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [31:0] value;
		logic               eor;
	} sorted_elem_t;

	typedef enum int {
		RX_ALWAYS,
		RX_MASK,
		RX_SPARSE
	} rx_mode_e;

	// dut signals
	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_ready;
	logic signed [31:0] value        = '0;
	logic               last         = 1'b0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [31:0] sorted_value;
	logic               end_of_run;

	// predicted run and expected sorted output
	logic signed [31:0] run_store [STORE_DEPTH];
	int                 run_count = 0;
	sorted_elem_t       expected_sorted_q[$];

	// stimulus and flow control state
	logic signed [31:0] run_buf[$];
	int                 items_sent     = 0;
	int                 mismatch_count = 0;
	int                 cycle_count    = 0;
	bit                 sender_bursty  = 1'b0;
	int                 burst_left     = 0;
	rx_mode_e           rx_mode        = RX_ALWAYS;
	int                 hold_request   = 0;
	int                 hold_left      = 0;
	logic [7:0]         rx_mask        = 8'hff;
	int                 rx_phase       = 0;

	bubble_sort_engine_core #(
		.MAX_ITEMS(STORE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.value(value),
		.last(last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sorted_value(sorted_value),
		.end_of_run(end_of_run)
	);

	// clock
	always #5 clk = ~clk;

	// run time guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[bubble_sort_engine_core] ERROR");
			$finish;
		end
	end

	// stable ascending sort of the collected run, queued as expected output
	function automatic void queue_sorted_run();
		logic signed [31:0] tmp;
		sorted_elem_t       elem;
		for (int p = 0; p < run_count; p++) begin
			for (int k = 0; k + 1 < run_count - p; k++) begin
				if (run_store[k] > run_store[k + 1]) begin
					tmp              = run_store[k];
					run_store[k]     = run_store[k + 1];
					run_store[k + 1] = tmp;
				end
			end
		end
		for (int k = 0; k < run_count; k++) begin
			elem.value = run_store[k];
			elem.eor   = (k + 1 == run_count);
			expected_sorted_q.push_back(elem);
		end
		run_count = 0;
	endfunction

	// track accepted items and check each accepted result
	always @(posedge clk) begin : scoreboard
		sorted_elem_t want;
		if (arst_n && item_valid && item_ready) begin
			if (run_count < STORE_DEPTH) begin
				run_store[run_count] = value;
				run_count++;
			end
			if (last)
				queue_sorted_run();
		end
		if (arst_n && result_valid && result_ready) begin
			if (expected_sorted_q.size() == 0) begin
				$error("unexpected result: sorted_value=%0d end_of_run=%0b",
					sorted_value, end_of_run);
				mismatch_count++;
			end else begin
				want = expected_sorted_q.pop_front();
				if (sorted_value !== want.value) begin
					$error("sorted_value: expected %0d, got %0d", want.value, sorted_value);
					mismatch_count++;
				end
				if (end_of_run !== want.eor) begin
					$error("end_of_run: expected %0b, got %0b", want.eor, end_of_run);
					mismatch_count++;
				end
			end
		end
	end

	// result side stalls, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: result_ready <= 1'b1;
				RX_MASK: begin
					if (rx_phase == 0)
						rx_mask = 8'($urandom()) | 8'h01;
					result_ready <= rx_mask[rx_phase];
					rx_phase = (rx_phase + 1) % 8;
				end
				default: result_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// mix of extremes, small values that repeat, and full range
	function automatic logic signed [31:0] random_element();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
			1, 2: return $signed($urandom_range(0, 15)) - 8;
			default: return $urandom();
		endcase
	endfunction

	// offer one item and wait until it is taken
	task automatic send_item(input logic signed [31:0] v, input logic l);
		int gap;
		if (sender_bursty) begin
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				gap = $urandom_range(1, 8);
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		item_valid <= 1'b1;
		value      <= v;
		last       <= l;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	// send the buffered run, last flag on its final item
	task automatic send_run_buf();
		for (int i = 0; i < run_buf.size(); i++)
			send_item(run_buf[i], i == run_buf.size() - 1);
		run_buf.delete();
	endtask

	// hold the item channel idle until every sorted value is out
	task automatic wait_for_results();
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_sorted_q.size() != 0);
	endtask

	// value extremes and single item runs
	task automatic test_extremes();
		sender_bursty = 1'b0;
		rx_mode       = RX_ALWAYS;
		run_buf = '{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1, VAL_MIN + 1, VAL_MAX - 1};
		send_run_buf();
		send_item(VAL_MIN, 1'b1);
		send_item(VAL_MAX, 1'b1);
		wait_for_results();
	endtask

	// presorted, reversed and repeated values
	task automatic test_ordering();
		sender_bursty = 1'b1;
		rx_mode       = RX_SPARSE;
		run_buf = '{-32'sd20, -32'sd3, 32'sd0, 32'sd7, 32'sd100};
		send_run_buf();
		run_buf = '{32'sd9, 32'sd4, 32'sd0, -32'sd4, -32'sd9};
		send_run_buf();
		run_buf = '{32'sd3, -32'sd2, 32'sd3, -32'sd2, 32'sd3};
		send_run_buf();
		wait_for_results();
	endtask

	// store filled to capacity, then the run's extra items are dropped
	task automatic test_store_full();
		sender_bursty = 1'b1;
		rx_mode       = RX_MASK;
		for (int i = 0; i < STORE_DEPTH; i++)
			run_buf.push_back(random_element());
		run_buf.push_back(VAL_MIN);
		run_buf.push_back(VAL_MAX);
		send_run_buf();
		wait_for_results();
	endtask

	// receiver holds off while the sender keeps offering items
	task automatic test_backpressure();
		sender_bursty = 1'b0;
		rx_mode       = RX_ALWAYS;
		hold_request  = LONG_HOLD;
		for (int i = 0; i < 8; i++)
			run_buf.push_back(random_element());
		send_run_buf();
		for (int i = 0; i < 10; i++)
			run_buf.push_back(random_element());
		send_run_buf();
		wait_for_results();
		run_buf = '{32'sd5, -32'sd5, 32'sd0};
		send_run_buf();
		wait_for_results();
	endtask

	// random runs, mostly short, now and then near full length or overfull
	task automatic test_random_runs();
		int len;
		int start;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			sender_bursty = ($urandom_range(0, 3) != 0);
			rx_mode       = rx_mode_e'($urandom_range(0, 2));
			if ($urandom_range(0, 15) == 0)
				len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
			else
				len = $urandom_range(1, 10);
			for (int i = 0; i < len; i++)
				run_buf.push_back(random_element());
			send_run_buf();
			if ($urandom_range(0, 4) == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	// test sequence
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_ordering();
		test_store_full();
		test_backpressure();
		test_random_runs();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (expected_sorted_q.size() != 0) begin
			$error("%0d sorted values never arrived", expected_sorted_q.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("[bubble_sort_engine_core] OK");
		else
			$display("[bubble_sort_engine_core] ERROR");
		$finish;
	end

endmodule
